FILE: design/b2d_pkg.sv
// shared types, constants and constant functions for the binary to decimal digit unit
package b2d_pkg;

   // code shown in place of a suppressed leading zero
   localparam logic [7:0] BLANK_CODE = 8'hFF;

   // decimal positions handled by the subtract stages: 10^9 down to 10^1
   localparam int unsigned STAGES = 9;

   // widest compare: nine times 10^9 needs 34 bits, keep some margin
   localparam int unsigned MULT_W = 36;

   // digits collected along the pipe, index is the power of ten
   typedef logic [9:1][3:0] digits_type;

   // one result item as it leaves the output register
   typedef struct packed {
      logic [7:0] e8;
      logic [7:0] e7;
      logic [7:0] e6;
      logic [7:0] e5;
      logic [7:0] e4;
      logic [7:0] e3;
      logic [7:0] e2;
      logic [7:0] e1;
      logic [3:0] e0;
   } result_type;

   // multiples 0..9 of 10^pos, evaluated at elaboration
   function automatic logic [9:0][MULT_W-1:0] multiples(input int unsigned pos);
      logic [MULT_W-1:0] p;
      logic [9:0][MULT_W-1:0] m;
      p = MULT_W'(1);
      for (int unsigned i = 0; i < pos; i++) begin
         p = p * MULT_W'(10);
      end
      for (int unsigned c = 0; c < 10; c++) begin
         m[c] = p * MULT_W'(c);
      end
      return m;
   endfunction

endpackage

FILE: design/b2d_blank.sv
// output stage: folds the top two digits, blanks leading zeros, holds the result item
module b2d_blank (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  b2d_pkg::digits_type    in_digits,
   input  logic [3:0]             in_ones,
   output logic                   out_valid,
   output b2d_pkg::result_type    out_result
);

   logic                out_valid_ff;
   b2d_pkg::result_type out_result_ff;
   b2d_pkg::result_type result_in;

   always_comb begin
      logic [8:1][7:0] vals;
      logic            lead;
      // hundred-millions field is the full quotient by 10^8, up to 42
      vals[8] = 8'({in_digits[9], 3'b000}) + 8'({in_digits[9], 1'b0}) + 8'(in_digits[8]);
      for (int k = 7; k >= 1; k--) begin
         vals[k] = {4'b0000, in_digits[k]};
      end
      lead = 1'b1;
      for (int k = 8; k >= 1; k--) begin
         if (lead && vals[k] == 8'd0) begin
            vals[k] = b2d_pkg::BLANK_CODE;
         end else begin
            lead = 1'b0;
         end
      end
      result_in.e8 = vals[8];
      result_in.e7 = vals[7];
      result_in.e6 = vals[6];
      result_in.e5 = vals[5];
      result_in.e4 = vals[4];
      result_in.e3 = vals[3];
      result_in.e2 = vals[2];
      result_in.e1 = vals[1];
      result_in.e0 = in_ones;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= result_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_result_ff;

endmodule

FILE: design/binary_to_decimal_digits_blanked_unit.sv
// top level: pipelined 32-bit binary to blanked decimal digit converter
//
// usage
//   req channel takes one item per cycle: a 32-bit unsigned value, accepted
//   at a rising edge with req_valid high and req_stall low
//   rsp channel gives one item per accepted value, in order: nine digit
//   fields, most significant first, accepted with rsp_valid high and
//   rsp_stall low
//   rsp_digit_e8 is the whole quotient by 10^8 (0..42); leading zero fields
//   down to rsp_digit_e1 read 8'hFF, rsp_digit_e0 is never blanked
// timing
//   from acceptance to rsp_valid an item passes nine compare and
//   subtract stages, one per power of ten from 10^9 to 10^1, then the
//   blanking and output register
//   throughput is one item per cycle when not stalled; each stage holds one
//   compare bank against nine constant multiples and one 32-bit subtract
// reset and stall
//   synchronous reset clears every stage valid bit; payload is not reset
//   the whole pipe moves on one shared advance: it freezes only while a
//   result sits in the output register and the receiver stalls, so req_stall
//   follows rsp_stall in that case and no item is lost or repeated
module binary_to_decimal_digits_blanked_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_digit_e8,
   output logic [7:0]  rsp_digit_e7,
   output logic [7:0]  rsp_digit_e6,
   output logic [7:0]  rsp_digit_e5,
   output logic [7:0]  rsp_digit_e4,
   output logic [7:0]  rsp_digit_e3,
   output logic [7:0]  rsp_digit_e2,
   output logic [7:0]  rsp_digit_e1,
   output logic [3:0]  rsp_digit_e0
);

   localparam int unsigned Stages = b2d_pkg::STAGES;
   localparam int unsigned MultW  = b2d_pkg::MULT_W;

   // pipe moves whenever the output register is empty or being taken
   logic advance;

   // per stage registers, stage i has resolved the digit of 10^(9-i)
   logic                valid_ff  [Stages];
   logic [31:0]         rest_ff   [Stages];
   b2d_pkg::digits_type digits_ff [Stages];

   b2d_pkg::result_type result;

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   for (genvar i = 0; i < Stages; i++) begin : g_stage
      localparam int unsigned Pos = Stages - i;
      localparam logic [9:0][MultW-1:0] Mult = b2d_pkg::multiples(Pos);

      logic                valid_src;
      logic [31:0]         rest_src;
      b2d_pkg::digits_type digits_src;
      logic                valid_in;
      logic [31:0]         rest_in;
      b2d_pkg::digits_type digits_in;

      if (i == 0) begin : g_first
         // first stage reads the input port directly
         assign valid_src  = req_valid;
         assign rest_src   = req_value;
         assign digits_src = '0;
      end else begin : g_next
         assign valid_src  = valid_ff[i-1];
         assign rest_src   = rest_ff[i-1];
         assign digits_src = digits_ff[i-1];
      end

      // remainder is below ten times 10^Pos here (the digit is at most 4 for the top stage),
      // so the digit is the largest multiple not above it
      always_comb begin
         logic [3:0]       digit;
         logic [MultW-1:0] sub;
         digit = 4'd0;
         sub   = '0;
         for (int c = 1; c < 10; c++) begin
            if ({{(MultW-32){1'b0}}, rest_src} >= Mult[c]) begin
               digit = 4'(c);
               sub   = Mult[c];
            end
         end
         valid_in       = valid_src;
         rest_in        = rest_src - sub[31:0];
         digits_in      = digits_src;
         digits_in[Pos] = digit;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (advance) begin
            valid_ff[i] <= valid_in;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rest_ff[i]   <= rest_in;
            digits_ff[i] <= digits_in;
         end
      end
   end

   // after the last stage the remainder is the ones digit
   b2d_blank u_blank (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (valid_ff[Stages-1]),
      .in_digits  (digits_ff[Stages-1]),
      .in_ones    (rest_ff[Stages-1][3:0]),
      .out_valid  (rsp_valid),
      .out_result (result)
   );

   assign rsp_digit_e8 = result.e8;
   assign rsp_digit_e7 = result.e7;
   assign rsp_digit_e6 = result.e6;
   assign rsp_digit_e5 = result.e5;
   assign rsp_digit_e4 = result.e4;
   assign rsp_digit_e3 = result.e3;
   assign rsp_digit_e2 = result.e2;
   assign rsp_digit_e1 = result.e1;
   assign rsp_digit_e0 = result.e0;

   // ones digit is always a real decimal digit
   a_ones_digit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_digit_e0 <= 4'd9)
      else $error("ones digit out of range");

   // a blanked tens field means every higher field is blanked too
   a_blank_run : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_digit_e1 == b2d_pkg::BLANK_CODE) |->
         (rsp_digit_e2 == b2d_pkg::BLANK_CODE && rsp_digit_e3 == b2d_pkg::BLANK_CODE &&
          rsp_digit_e4 == b2d_pkg::BLANK_CODE && rsp_digit_e5 == b2d_pkg::BLANK_CODE &&
          rsp_digit_e6 == b2d_pkg::BLANK_CODE && rsp_digit_e7 == b2d_pkg::BLANK_CODE &&
          rsp_digit_e8 == b2d_pkg::BLANK_CODE))
      else $error("blanking not contiguous from the top");

   // top field is either blank or a quotient no larger than 42
   a_top_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digit_e8 == b2d_pkg::BLANK_CODE || rsp_digit_e8 <= 8'd42))
      else $error("top quotient out of range");

   // pipe holds still while the output is stalled
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(valid_ff[0]) && $stable(rest_ff[0]))
      else $error("pipe moved during output stall");

endmodule

FILE: verif/tb_binary_to_decimal_digits_blanked_unit.sv
// testbench for the binary to blanked decimal digit unit: predicted digits against rsp items
module tb_binary_to_decimal_digits_blanked_unit;
   timeunit 1ns;
   timeprecision 1ps;

   // run shape
   localparam int unsigned RANDOM_ITEMS = 550;
   localparam int unsigned MAX_IDLE     = 16;
   localparam int unsigned LONG_HOLD    = 80;   // receiver hold-off to back the pipe up
   localparam int unsigned SETTLE       = 24;   // quiet time after the drain to catch stray results
   localparam int unsigned STUCK_LIMIT  = 2000; // cycles with no handshake on either side

   // expected digits for every accepted value, checked in order
   class digit_ledger;
      typedef struct {
         logic [31:0]         value;
         b2d_pkg::result_type digits;
      } pending_type;

      pending_type awaited[$];
      int unsigned faults;

      // nine digit positions, top one is the whole quotient by 10^8
      function b2d_pkg::result_type blanked_digits(logic [31:0] value);
         logic [31:0]         rest;
         logic [31:0]         scale;
         logic [7:0]          d [0:8];
         bit                  leading;
         b2d_pkg::result_type r;
         rest  = value;
         scale = 32'd100000000;
         for (int p = 8; p >= 0; p--) begin
            d[p]  = 8'(rest / scale);
            rest  = rest % scale;
            scale = scale / 32'd10;
         end
         // only zeros in front of the first nonzero digit go blank, never the ones digit
         leading = 1'b1;
         for (int p = 8; p >= 1; p--) begin
            if (leading && d[p] == 8'd0) begin
               d[p] = b2d_pkg::BLANK_CODE;
            end else begin
               leading = 1'b0;
            end
         end
         r.e8 = d[8];
         r.e7 = d[7];
         r.e6 = d[6];
         r.e5 = d[5];
         r.e4 = d[4];
         r.e3 = d[3];
         r.e2 = d[2];
         r.e1 = d[1];
         r.e0 = d[0][3:0];
         return r;
      endfunction

      function void note_value(logic [31:0] value);
         pending_type p;
         p.value  = value;
         p.digits = blanked_digits(value);
         awaited.push_back(p);
      endfunction

      function void compare_field(string name, logic [31:0] value, int unsigned want,
                                  int unsigned got);
         if (want != got) begin
            faults++;
            $display("%0t ns: value %0d, %s expected %0d, actual %0d",
                     $time, value, name, want, got);
         end
      endfunction

      function void check_digits(b2d_pkg::result_type got);
         pending_type p;
         if (awaited.size() == 0) begin
            faults++;
            $display("%0t ns: result with nothing expected, expected none, actual %h",
                     $time, got);
            return;
         end
         p = awaited.pop_front();
         compare_field("digit_e8", p.value, p.digits.e8, got.e8);
         compare_field("digit_e7", p.value, p.digits.e7, got.e7);
         compare_field("digit_e6", p.value, p.digits.e6, got.e6);
         compare_field("digit_e5", p.value, p.digits.e5, got.e5);
         compare_field("digit_e4", p.value, p.digits.e4, got.e4);
         compare_field("digit_e3", p.value, p.digits.e3, got.e3);
         compare_field("digit_e2", p.value, p.digits.e2, got.e2);
         compare_field("digit_e1", p.value, p.digits.e1, got.e1);
         compare_field("digit_e0", p.value, p.digits.e0, got.e0);
      endfunction
   endclass

   // block ports, all inputs known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_value = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_digit_e8;
   logic [7:0]  rsp_digit_e7;
   logic [7:0]  rsp_digit_e6;
   logic [7:0]  rsp_digit_e5;
   logic [7:0]  rsp_digit_e4;
   logic [7:0]  rsp_digit_e3;
   logic [7:0]  rsp_digit_e2;
   logic [7:0]  rsp_digit_e1;
   logic [3:0]  rsp_digit_e0;

   // shared between the sender and the receiver; the stuck counter is the watchdog's
   digit_ledger ledger = new();
   bit          no_idle = 1'b0;      // both sides run without gaps while set
   bit          hold_request = 1'b0; // receiver picks this up as one long hold-off
   int unsigned stuck_cycles = 0;

   binary_to_decimal_digits_blanked_unit uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_digit_e8 (rsp_digit_e8),
      .rsp_digit_e7 (rsp_digit_e7),
      .rsp_digit_e6 (rsp_digit_e6),
      .rsp_digit_e5 (rsp_digit_e5),
      .rsp_digit_e4 (rsp_digit_e4),
      .rsp_digit_e3 (rsp_digit_e3),
      .rsp_digit_e2 (rsp_digit_e2),
      .rsp_digit_e1 (rsp_digit_e1),
      .rsp_digit_e0 (rsp_digit_e0)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // offer one value after a random gap, return in the step it is taken
   task automatic send_value(input logic [31:0] value);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!(req_valid && !req_stall));
      ledger.note_value(value);
   endtask

   // sender goes quiet until every outstanding item has come back
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (ledger.awaited.size() != 0) @(posedge clock);
   endtask

   // mix of full-range words, short numbers, numbers full of inner zeros and near-max words
   function automatic logic [31:0] draw_value();
      int unsigned scale;
      logic [31:0] v;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: begin
            // pick a digit count so every blanking depth gets hit
            scale = 1;
            repeat ($urandom_range(1, 9)) scale = scale * 10;
            v = $urandom_range(0, scale - 1);
         end
         2: begin
            // half the positions zero, plus an optional top quotient of 10 and more
            v = 32'd0;
            scale = 1;
            repeat (9) begin
               if ($urandom_range(0, 1) == 1) v = v + scale * $urandom_range(1, 9);
               scale = scale * 10;
            end
            v = v + 32'd1000000000 * $urandom_range(0, 3);
         end
         default: v = 32'hFFFF_FFFF - $urandom_range(0, 400000000);
      endcase
      return v;
   endfunction

   // receiver: random hold-off per item (or one long hold-off on request), then take and check one result
   initial begin
      int unsigned         hold;
      b2d_pkg::result_type got;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            hold = LONG_HOLD;
            hold_request = 1'b0;
         end else begin
            hold = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         got.e8 = rsp_digit_e8;
         got.e7 = rsp_digit_e7;
         got.e6 = rsp_digit_e6;
         got.e5 = rsp_digit_e5;
         got.e4 = rsp_digit_e4;
         got.e3 = rsp_digit_e3;
         got.e2 = rsp_digit_e2;
         got.e1 = rsp_digit_e1;
         got.e0 = rsp_digit_e0;
         ledger.check_digits(got);
      end
   end

   // watchdog: any handshake on either side counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
         $display("binary_to_decimal_digits_blanked_unit verification failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // stimulus and end of run
   initial begin
      logic [31:0] corner_values [$] = '{
         32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd1000,
         32'd10000, 32'd100000, 32'd1000000, 32'd10000000, 32'd99999999,
         32'd100000000, 32'd100000001, 32'd999999999, 32'd1000000000,
         32'd1234567890, 32'd2147483648, 32'd4200000000, 32'hFFFF_FFFF,
         32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678
      };

      // synchronous reset held from time zero, then released once for good
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: zero, single digits, 1 then zeros at every width, top quotient up to 42
      foreach (corner_values[i]) send_value(corner_values[i]);
      pause_until_drained();

      // random: streaming stretch, long receiver hold-offs under a gapless sender, drains
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 120 == 0 && i != 0) pause_until_drained();
         if (i % 120 == 60) begin
            no_idle = 1'b1;
            if (i != 60) hold_request = 1'b1;
         end
         if (i % 120 == 100) no_idle = 1'b0;
         send_value(draw_value());
      end

      // wait out everything still in flight, then a settle time for strays
      pause_until_drained();
      repeat (SETTLE) @(posedge clock);

      if (ledger.faults == 0 && ledger.awaited.size() == 0) begin
         $display("binary_to_decimal_digits_blanked_unit verification clean");
      end else begin
         $display("binary_to_decimal_digits_blanked_unit verification failed");
      end
      $finish;
   end

endmodule
